[sv/rsru_pkg.sv]
// Package for the raw sensor row unpacker: widths, mode codes, register indexes
// and small byte-assembly helper functions.
// No dependencies.
`default_nettype none

package rsru_pkg;

   localparam int MAX_ROW_SAMPLES = 8192;
   localparam int MAX_ROW_BYTES   = 16384;

   localparam int MODE_W    = 3;
   localparam int RBYTES_W  = 15;
   localparam int RSAMP_W   = 14;
   localparam int SHIFT_W   = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 15;
   localparam int PIXEL_W   = 16;
   localparam int COLUMN_W  = 13;
   localparam int GROUP_DEPTH = 12;
   localparam int BATCH_DEPTH = 8;

   typedef logic [MODE_W-1:0]    mode_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam mode_type MODE_BE12      = 3'd0;
   localparam mode_type MODE_SHUF12    = 3'd1;
   localparam mode_type MODE_PACK10    = 3'd2;
   localparam mode_type MODE_BE16      = 3'd3;
   localparam mode_type MODE_LE16      = 3'd4;
   localparam mode_type MODE_LE12_PAD  = 3'd5;

   localparam csr_idx_type CSR_UNPACK_MODE = 3'd0;
   localparam csr_idx_type CSR_ROW_BYTES   = 3'd1;
   localparam csr_idx_type CSR_ROW_SAMPLES = 3'd2;
   localparam csr_idx_type CSR_RIGHT_SHIFT = 3'd3;

   // bytes per group; zero for unused modes
   function automatic logic [4:0] group_len(input mode_type m);
      logic [4:0] r;
      case (m)
         MODE_BE12:     r = 5'd3;
         MODE_SHUF12:   r = 5'd12;
         MODE_PACK10:   r = 5'd5;
         MODE_BE16:     r = 5'd2;
         MODE_LE16:     r = 5'd2;
         MODE_LE12_PAD: r = 5'd16;
         default:       r = 5'd0;
      endcase
      return r;
   endfunction

   // samples produced by a completed group; per completed triple in the padded mode
   function automatic logic [3:0] group_samples(input mode_type m);
      logic [3:0] r;
      case (m)
         MODE_BE12:     r = 4'd2;
         MODE_SHUF12:   r = 4'd8;
         MODE_PACK10:   r = 4'd4;
         MODE_BE16:     r = 4'd1;
         MODE_LE16:     r = 4'd1;
         MODE_LE12_PAD: r = 4'd2;
         default:       r = 4'd0;
      endcase
      return r;
   endfunction

   // byte slot within a triple for the padded little-endian mode
   function automatic logic [3:0] mod3(input logic [3:0] v);
      logic [3:0] r;
      case (v)
         4'd0, 4'd3, 4'd6, 4'd9,  4'd12, 4'd15: r = 4'd0;
         4'd1, 4'd4, 4'd7, 4'd10, 4'd13:        r = 4'd1;
         default:                               r = 4'd2;
      endcase
      return r;
   endfunction

   function automatic logic [11:0] hi12(input logic [7:0] a, input logic [7:0] b);
      return {a, b[7:4]};
   endfunction

   function automatic logic [11:0] lo12(input logic [7:0] a, input logic [7:0] b);
      return {a[3:0], b};
   endfunction

endpackage

`default_nettype wire

[sv/raw_sensor_row_unpacker_unit.sv]
// Top level of the raw sensor row unpacker: byte grouping, sample assembly and an
// eight-entry result batch draining one sample per unstalled cycle. Uses rsru_pkg.
`default_nettype none

// One raw byte is accepted per cycle unless req_stall is high. The byte that
// completes a group turns it into up to eight samples in the same cycle; they
// are loaded into a batch register and leave on the rsp channel one per cycle
// unless rsp_stall is high, so a completing byte waits only until an earlier
// batch hands over its final sample. Bytes that complete no group are never
// held up by the result side. In the steady state every mode averages at most
// one sample per byte, so without rsp_stall the sustained rate is one byte per
// cycle. The rsp_last flag closes the samples of one byte; rsp_row_end marks
// the last kept sample of a row. Configuration must be written only while the
// block is idle (not enforced); writing unpack_mode restarts the current group.
module raw_sensor_row_unpacker_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [7:0]                     req_raw_byte,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [rsru_pkg::PIXEL_W-1:0]   rsp_pixel,
   output      logic [rsru_pkg::COLUMN_W-1:0]  rsp_column,
   output      logic                           rsp_row_end,
   output      logic                           rsp_last,
   input  wire logic                           csr_wr_en,
   input  wire logic [rsru_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rsru_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import rsru_pkg::*;

   // configuration
   mode_type              mode_ff;
   logic [RBYTES_W-1:0]   row_bytes_ff;
   logic [RSAMP_W-1:0]    row_samples_ff;
   logic [SHIFT_W-1:0]    right_shift_ff;

   // row state
   logic [RBYTES_W-1:0]   byte_pos_ff,  byte_pos_in;
   logic [RSAMP_W-1:0]    samp_pos_ff,  samp_pos_in;
   logic [3:0]            grp_idx_ff,   grp_idx_in;
   logic [7:0]            grp_ff [GROUP_DEPTH];
   logic [7:0]            grp_in [GROUP_DEPTH];

   // result batch
   logic [PIXEL_W-1:0]    bpix_ff  [BATCH_DEPTH];
   logic [COLUMN_W-1:0]   bcol_ff  [BATCH_DEPTH];
   logic                  bend_ff  [BATCH_DEPTH];
   logic [3:0]            bcnt_ff, bcnt_in;
   logic [2:0]            bidx_ff, bidx_in;

   logic [4:0]            glen;
   logic [3:0]            gsamp;
   logic                  mode_on;
   logic [4:0]            gi_norm;
   logic [4:0]            gi_next;
   logic [3:0]            gi_after;
   logic                  grp_done;
   logic [RSAMP_W-1:0]    rs_eff;
   logic [RBYTES_W:0]     rb_eff;
   logic                  row_last;
   logic [RSAMP_W-1:0]    rs_left;
   logic                  will_emit;
   logic [3:0]            emit_cnt;
   logic [11:0]           p12 [BATCH_DEPTH];
   logic [15:0]           word16;
   logic [PIXEL_W-1:0]    samp   [BATCH_DEPTH];
   logic [RSAMP_W-1:0]    col_full [BATCH_DEPTH];
   logic                  end_flag [BATCH_DEPTH];
   logic                  pop, pop_last, batch_free, accept, load;

   always_comb begin
      glen    = group_len(mode_ff);
      gsamp   = group_samples(mode_ff);
      mode_on = (glen != 5'd0);
      gi_norm = ({1'b0, grp_idx_ff} >= glen) ? 5'd0 : {1'b0, grp_idx_ff};
      gi_next = gi_norm + 5'd1;
      gi_after = (gi_next >= glen) ? 4'd0 : gi_next[3:0];

      case (mode_ff)
         MODE_BE12:     grp_done = (gi_next == 5'd3);
         MODE_SHUF12:   grp_done = (gi_next == 5'd12);
         MODE_PACK10:   grp_done = (gi_next == 5'd5);
         MODE_BE16:     grp_done = (gi_next == 5'd2);
         MODE_LE16:     grp_done = (gi_next == 5'd2);
         MODE_LE12_PAD: grp_done = (gi_next == 5'd3) || (gi_next == 5'd6) ||
                                   (gi_next == 5'd9) || (gi_next == 5'd12) ||
                                   (gi_next == 5'd15);
         default:       grp_done = 1'b0;
      endcase

      rs_eff = (row_samples_ff > RSAMP_W'(MAX_ROW_SAMPLES)) ?
               RSAMP_W'(MAX_ROW_SAMPLES) : row_samples_ff;
      if (row_bytes_ff == '0)
         rb_eff = (RBYTES_W+1)'(1);
      else if (row_bytes_ff > RBYTES_W'(MAX_ROW_BYTES))
         rb_eff = (RBYTES_W+1)'(MAX_ROW_BYTES);
      else
         rb_eff = {1'b0, row_bytes_ff};
      row_last = ({1'b0, byte_pos_ff} + (RBYTES_W+1)'(1)) >= rb_eff;

      rs_left   = rs_eff - samp_pos_ff;
      will_emit = mode_on && grp_done && (samp_pos_ff < rs_eff);
      if (!will_emit)
         emit_cnt = 4'd0;
      else if (rs_left >= RSAMP_W'(gsamp))
         emit_cnt = gsamp;
      else
         emit_cnt = rs_left[3:0];

      // group bytes with the incoming byte in place
      for (int i = 0; i < GROUP_DEPTH; i++)
         grp_in[i] = grp_ff[i];
      if (mode_ff == MODE_LE12_PAD) begin
         if (gi_norm < 5'd15)
            grp_in[mod3(gi_norm[3:0])] = req_raw_byte;
      end else if (mode_on && gi_norm < 5'd12) begin
         grp_in[gi_norm[3:0]] = req_raw_byte;
      end

      for (int i = 0; i < BATCH_DEPTH; i++)
         p12[i] = '0;
      word16 = '0;
      case (mode_ff)
         MODE_BE12: begin
            p12[0] = hi12(grp_in[0], grp_in[1]);
            p12[1] = lo12(grp_in[1], grp_in[2]);
         end
         MODE_SHUF12: begin
            p12[0] = hi12(grp_in[3],  grp_in[2]);
            p12[1] = lo12(grp_in[2],  grp_in[1]);
            p12[2] = hi12(grp_in[0],  grp_in[7]);
            p12[3] = lo12(grp_in[7],  grp_in[6]);
            p12[4] = hi12(grp_in[5],  grp_in[4]);
            p12[5] = lo12(grp_in[4],  grp_in[11]);
            p12[6] = hi12(grp_in[10], grp_in[9]);
            p12[7] = lo12(grp_in[9],  grp_in[8]);
         end
         MODE_PACK10: begin
            p12[0] = {grp_in[0],      grp_in[1][7:6], 2'b00};
            p12[1] = {grp_in[1][5:0], grp_in[2][7:4], 2'b00};
            p12[2] = {grp_in[2][3:0], grp_in[3][7:2], 2'b00};
            p12[3] = {grp_in[3][1:0], grp_in[4],      2'b00};
         end
         MODE_BE16: word16 = {grp_in[0], grp_in[1]} >> right_shift_ff;
         MODE_LE16: word16 = {grp_in[1], grp_in[0]} >> right_shift_ff;
         MODE_LE12_PAD: begin
            p12[0] = lo12(grp_in[1], grp_in[0]);
            p12[1] = hi12(grp_in[2], grp_in[1]);
         end
         default: ;
      endcase

      for (int i = 0; i < BATCH_DEPTH; i++) begin
         samp[i]     = {4'b0000, p12[i]};
         col_full[i] = samp_pos_ff + RSAMP_W'(i);
         end_flag[i] = (col_full[i] + RSAMP_W'(1)) == rs_eff;
      end
      if (mode_ff == MODE_BE16 || mode_ff == MODE_LE16)
         samp[0] = word16;
   end

   // handshake
   always_comb begin
      rsp_valid  = (bcnt_ff != 4'd0);
      pop        = rsp_valid && !rsp_stall;
      pop_last   = pop && (({1'b0, bidx_ff} + 4'd1) == bcnt_ff);
      batch_free = (bcnt_ff == 4'd0) || pop_last;
      req_stall  = will_emit && !batch_free;
      accept     = req_valid && !req_stall;
      load       = accept && will_emit;

      rsp_pixel   = bpix_ff[bidx_ff];
      rsp_column  = bcol_ff[bidx_ff];
      rsp_row_end = bend_ff[bidx_ff];
      rsp_last    = (({1'b0, bidx_ff} + 4'd1) == bcnt_ff);

      if (load) begin
         bcnt_in = emit_cnt;
         bidx_in = '0;
      end else if (pop_last) begin
         bcnt_in = '0;
         bidx_in = '0;
      end else if (pop) begin
         bcnt_in = bcnt_ff;
         bidx_in = bidx_ff + 3'd1;
      end else begin
         bcnt_in = bcnt_ff;
         bidx_in = bidx_ff;
      end

      if (row_last) begin
         byte_pos_in = '0;
         samp_pos_in = '0;
         grp_idx_in  = '0;
      end else begin
         byte_pos_in = byte_pos_ff + RBYTES_W'(1);
         samp_pos_in = samp_pos_ff + RSAMP_W'(emit_cnt);
         grp_idx_in  = mode_on ? gi_after : grp_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_BE12;
         row_bytes_ff   <= RBYTES_W'(1);
         row_samples_ff <= RSAMP_W'(1);
         right_shift_ff <= '0;
         byte_pos_ff    <= '0;
         samp_pos_ff    <= '0;
         grp_idx_ff     <= '0;
         bcnt_ff        <= '0;
         bidx_ff        <= '0;
      end else begin
         bcnt_ff <= bcnt_in;
         bidx_ff <= bidx_in;
         if (accept) begin
            byte_pos_ff <= byte_pos_in;
            samp_pos_ff <= samp_pos_in;
            grp_idx_ff  <= grp_idx_in;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_UNPACK_MODE: begin
                  mode_ff    <= csr_wr_data[MODE_W-1:0];
                  grp_idx_ff <= '0;
               end
               CSR_ROW_BYTES:   row_bytes_ff   <= csr_wr_data[RBYTES_W-1:0];
               CSR_ROW_SAMPLES: row_samples_ff <= csr_wr_data[RSAMP_W-1:0];
               CSR_RIGHT_SHIFT: right_shift_ff <= csr_wr_data[SHIFT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < GROUP_DEPTH; i++)
            grp_ff[i] <= grp_in[i];
      end
      if (load) begin
         for (int i = 0; i < BATCH_DEPTH; i++) begin
            bpix_ff[i] <= samp[i];
            bcol_ff[i] <= col_full[i][COLUMN_W-1:0];
            bend_ff[i] <= end_flag[i];
         end
      end
   end

endmodule

`default_nettype wire

[verif/raw_sensor_row_unpacker_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for raw_sensor_row_unpacker_unit: directed and random
// byte streams in every unpack mode, predicted samples checked in order.
// Depends on rsru_pkg and the raw_sensor_row_unpacker_unit RTL.

module raw_sensor_row_unpacker_unit_tb;
   import rsru_pkg::*;

   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel;
      logic [COLUMN_W-1:0] column;
      logic                row_end;
      logic                last;
   } sample_type;

   // codes the package leaves out: modes that produce nothing, unmapped registers
   localparam mode_type    MODE_NONE6   = 3'd6;
   localparam mode_type    MODE_NONE7   = 3'd7;
   localparam csr_idx_type CSR_SPARE_LO = 3'd4;
   localparam csr_idx_type CSR_SPARE_HI = 3'd7;

   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 4000;
   localparam int RANDOM_ITEMS  = 80;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_raw_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [PIXEL_W-1:0]    rsp_pixel;
   logic [COLUMN_W-1:0]   rsp_column;
   logic                  rsp_row_end;
   logic                  rsp_last;
   logic                  csr_wr_en    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data  = '0;

   raw_sensor_row_unpacker_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_raw_byte(req_raw_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pixel   (rsp_pixel),
      .rsp_column  (rsp_column),
      .rsp_row_end (rsp_row_end),
      .rsp_last    (rsp_last),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // predictor state and its copy of the registers
   mode_type             cur_mode        = MODE_BE12;
   logic [RBYTES_W-1:0]  cur_row_bytes   = RBYTES_W'(1);
   logic [RSAMP_W-1:0]   cur_row_samples = RSAMP_W'(1);
   logic [SHIFT_W-1:0]   cur_shift       = '0;
   int unsigned          byte_pos        = 0;
   int unsigned          samp_pos        = 0;
   int unsigned          grp_idx         = 0;
   logic [7:0]           grp_bytes [GROUP_DEPTH];

   logic [7:0] raw_bytes_to_send [$];
   sample_type expected_samples [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requested = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int error_count = 0;

   function automatic int unsigned bytes_per_group(input mode_type m);
      case (m)
         MODE_BE12:     return 3;
         MODE_SHUF12:   return 12;
         MODE_PACK10:   return 5;
         MODE_BE16:     return 2;
         MODE_LE16:     return 2;
         MODE_LE12_PAD: return 16;
         default:       return 0;
      endcase
   endfunction

   function automatic logic [7:0] random_raw_byte();
      if ($urandom_range(0, 7) == 0) begin
         return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Predicts the samples that one accepted byte releases.
   task automatic unpack_byte(input logic [7:0] b);
      logic [15:0] vals [$];
      int unsigned gi, glen, rb, rs;
      int          produced;
      sample_type  s;
      glen = bytes_per_group(cur_mode);
      produced = 0;
      if (glen != 0) begin
         gi = grp_idx;
         if (gi >= glen) gi = 0;
         // padded mode reuses three slots, one per byte of a triple
         if (cur_mode == MODE_LE12_PAD) begin
            if (gi < 15) grp_bytes[gi % 3] = b;
         end else if (gi < GROUP_DEPTH) begin
            grp_bytes[gi] = b;
         end
         gi++;
         case (cur_mode)
            MODE_BE12: if (gi == 3) begin
               vals.push_back({4'h0, grp_bytes[0], grp_bytes[1][7:4]});
               vals.push_back({4'h0, grp_bytes[1][3:0], grp_bytes[2]});
            end
            MODE_SHUF12: if (gi == 12) begin
               vals.push_back({4'h0, grp_bytes[3], grp_bytes[2][7:4]});
               vals.push_back({4'h0, grp_bytes[2][3:0], grp_bytes[1]});
               vals.push_back({4'h0, grp_bytes[0], grp_bytes[7][7:4]});
               vals.push_back({4'h0, grp_bytes[7][3:0], grp_bytes[6]});
               vals.push_back({4'h0, grp_bytes[5], grp_bytes[4][7:4]});
               vals.push_back({4'h0, grp_bytes[4][3:0], grp_bytes[11]});
               vals.push_back({4'h0, grp_bytes[10], grp_bytes[9][7:4]});
               vals.push_back({4'h0, grp_bytes[9][3:0], grp_bytes[8]});
            end
            MODE_PACK10: if (gi == 5) begin
               vals.push_back({4'h0, grp_bytes[0], grp_bytes[1][7:6], 2'b00});
               vals.push_back({4'h0, grp_bytes[1][5:0], grp_bytes[2][7:4], 2'b00});
               vals.push_back({4'h0, grp_bytes[2][3:0], grp_bytes[3][7:2], 2'b00});
               vals.push_back({4'h0, grp_bytes[3][1:0], grp_bytes[4], 2'b00});
            end
            MODE_BE16: if (gi == 2) begin
               vals.push_back({grp_bytes[0], grp_bytes[1]} >> cur_shift);
            end
            MODE_LE16: if (gi == 2) begin
               vals.push_back({grp_bytes[1], grp_bytes[0]} >> cur_shift);
            end
            MODE_LE12_PAD: if (gi <= 15 && gi % 3 == 0) begin
               vals.push_back({4'h0, grp_bytes[1][3:0], grp_bytes[0]});
               vals.push_back({4'h0, grp_bytes[2], grp_bytes[1][7:4]});
            end
            default: ;
         endcase
         if (gi >= glen) gi = 0;
         grp_idx = gi;
      end

      rs = (32'(cur_row_samples) > MAX_ROW_SAMPLES) ? MAX_ROW_SAMPLES :
           32'(cur_row_samples);
      foreach (vals[i]) begin
         if (samp_pos < rs && produced < BATCH_DEPTH) begin
            s.pixel   = vals[i];
            s.column  = COLUMN_W'(samp_pos);
            s.row_end = (samp_pos + 1 == rs);
            s.last    = 1'b0;
            expected_samples.push_back(s);
            samp_pos++;
            produced++;
         end
      end

      rb = 32'(cur_row_bytes);
      if (rb == 0) rb = 1;
      if (rb > MAX_ROW_BYTES) rb = MAX_ROW_BYTES;
      if (byte_pos + 1 >= rb) begin
         byte_pos = 0;
         samp_pos = 0;
         grp_idx = 0;
      end else begin
         byte_pos++;
      end

      if (produced > 0) begin
         s = expected_samples.pop_back();
         s.last = 1'b1;
         expected_samples.push_back(s);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Register write at idle; the predictor copy changes at the same edge.
   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_UNPACK_MODE: begin
            cur_mode = value[MODE_W-1:0];
            grp_idx = 0;
         end
         CSR_ROW_BYTES:   cur_row_bytes = value[RBYTES_W-1:0];
         CSR_ROW_SAMPLES: cur_row_samples = value[RSAMP_W-1:0];
         CSR_RIGHT_SHIFT: cur_shift = value[SHIFT_W-1:0];
         default: ;
      endcase
   endtask

   // Sender pauses until every predicted sample is back, then lets bytes that
   // released nothing settle.
   task automatic wait_drained();
      @(negedge clock);
      while (raw_bytes_to_send.size() != 0 || req_valid || expected_samples.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (raw_bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid    <= 1'b1;
            req_raw_byte <= raw_bytes_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // sample receiver, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requested) begin
         hold_served <= hold_requested;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // monitor: predict on accepted bytes, check accepted samples
   always @(posedge clock) begin : check_samples
      sample_type want;
      if (!reset) begin
         if (req_valid && !req_stall) unpack_byte(req_raw_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               error_count++;
               $display("%0t: unexpected sample, expected none, actual pixel %0h column %0d",
                        $time, rsp_pixel, rsp_column);
            end else begin
               want = expected_samples.pop_front();
               check_field("pixel", want.pixel, rsp_pixel);
               check_field("column", 16'(want.column), 16'(rsp_column));
               check_field("row_end", 16'(want.row_end), 16'(rsp_row_end));
               check_field("last", 16'(want.last), 16'(rsp_last));
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      mode_type    mode;
      int unsigned glen, per_group, groups, rbytes, rsamp, nbytes, counted;
      counted = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: one-byte rows, so groups never complete
      raw_bytes_to_send.push_back(8'hFF);
      raw_bytes_to_send.push_back(8'h00);
      wait_drained();

      // zero row length acts as one byte
      write_csr(CSR_UNPACK_MODE, CSR_DATA_W'(MODE_BE16));
      write_csr(CSR_ROW_BYTES, '0);
      raw_bytes_to_send.push_back(8'hFF);
      raw_bytes_to_send.push_back(8'hFF);
      wait_drained();

      // oversize row length clamps; zero samples keeps nothing
      write_csr(CSR_ROW_BYTES, '1);
      write_csr(CSR_ROW_SAMPLES, '0);
      raw_bytes_to_send.push_back(8'h12);
      raw_bytes_to_send.push_back(8'h34);
      wait_drained();

      write_csr(CSR_ROW_SAMPLES, '1);
      write_csr(CSR_RIGHT_SHIFT, '1);
      raw_bytes_to_send.push_back(8'hFF);
      raw_bytes_to_send.push_back(8'hFF);
      wait_drained();

      write_csr(CSR_RIGHT_SHIFT, '0);
      raw_bytes_to_send.push_back(8'hFF);
      raw_bytes_to_send.push_back(8'hFF);
      raw_bytes_to_send.push_back(8'h00);
      raw_bytes_to_send.push_back(8'h00);
      wait_drained();

      write_csr(CSR_UNPACK_MODE, CSR_DATA_W'(MODE_LE16));
      write_csr(CSR_RIGHT_SHIFT, CSR_DATA_W'(4));
      raw_bytes_to_send.push_back(8'hA5);
      raw_bytes_to_send.push_back(8'h3C);
      wait_drained();

      // unused modes: bytes count toward the row but yield nothing;
      // the lowered row length ends the row on the next byte
      write_csr(CSR_UNPACK_MODE, CSR_DATA_W'(MODE_NONE6));
      raw_bytes_to_send.push_back(8'h5A);
      raw_bytes_to_send.push_back(8'hC3);
      wait_drained();
      write_csr(CSR_ROW_BYTES, CSR_DATA_W'(3));
      write_csr(CSR_UNPACK_MODE, CSR_DATA_W'(MODE_NONE7));
      raw_bytes_to_send.push_back(8'h81);
      wait_drained();

      // unmapped registers are ignored
      write_csr(CSR_SPARE_LO, '1);
      write_csr(CSR_SPARE_HI, '0);

      // sample limit inside a group, then a partial group cut by a short row
      write_csr(CSR_UNPACK_MODE, CSR_DATA_W'(MODE_BE12));
      write_csr(CSR_ROW_BYTES, CSR_DATA_W'(100));
      write_csr(CSR_ROW_SAMPLES, CSR_DATA_W'(3));
      raw_bytes_to_send.push_back(8'hFF);
      raw_bytes_to_send.push_back(8'hFF);
      raw_bytes_to_send.push_back(8'hFF);
      raw_bytes_to_send.push_back(8'h00);
      raw_bytes_to_send.push_back(8'h00);
      raw_bytes_to_send.push_back(8'h00);
      raw_bytes_to_send.push_back(8'hAB);
      wait_drained();
      write_csr(CSR_ROW_BYTES, CSR_DATA_W'(2));
      raw_bytes_to_send.push_back(8'h23);
      raw_bytes_to_send.push_back(8'h45);
      wait_drained();

      // random phases, mostly whole rows of whole groups
      while (counted < RANDOM_ITEMS) begin
         if (counted < RANDOM_ITEMS / 3) begin
            send_idle_pct = 7;
            recv_idle_pct = 70;
         end else if (counted < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 70;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if ($urandom_range(0, 19) == 0) mode = mode_type'($urandom_range(6, 7));
         else mode = mode_type'($urandom_range(0, 5));
         glen = bytes_per_group(mode);
         case (mode)
            MODE_BE12:     per_group = 2;
            MODE_SHUF12:   per_group = 8;
            MODE_PACK10:   per_group = 4;
            MODE_BE16:     per_group = 1;
            MODE_LE16:     per_group = 1;
            MODE_LE12_PAD: per_group = 10;
            default:       per_group = 0;
         endcase
         groups = (glen > 8) ? $urandom_range(1, 2) : $urandom_range(1, 4);
         if (glen == 0) begin
            rbytes = $urandom_range(1, 8);
            rsamp  = $urandom_range(0, 8);
         end else if ($urandom_range(0, 4) != 0) begin
            rbytes = glen * groups;
            if ($urandom_range(0, 3) == 0) rbytes += $urandom_range(1, glen - 1);
            case ($urandom_range(0, 3))
               0:       rsamp = per_group * groups;
               1:       rsamp = $urandom_range(1, per_group * groups);
               2:       rsamp = per_group * groups + $urandom_range(1, 6);
               default: rsamp = $urandom_range(0, 2);
            endcase
         end else begin
            rbytes = $urandom_range(1, 40);
            rsamp  = $urandom_range(0, 40);
         end
         write_csr(CSR_UNPACK_MODE, CSR_DATA_W'(mode));
         write_csr(CSR_ROW_BYTES, CSR_DATA_W'(rbytes));
         write_csr(CSR_ROW_SAMPLES, CSR_DATA_W'(rsamp));
         write_csr(CSR_RIGHT_SHIFT, CSR_DATA_W'($urandom_range(0, 15)));
         // sometimes stop mid-row so the next mode write lands inside a row
         nbytes = rbytes * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0) nbytes += $urandom_range(0, rbytes - 1);
         @(negedge clock);
         repeat (nbytes) raw_bytes_to_send.push_back(random_raw_byte());
         if (glen != 0) counted += nbytes;
         wait_drained();
      end

      // long receiver hold-off while bytes keep coming, so the input backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_UNPACK_MODE, CSR_DATA_W'(MODE_BE12));
      write_csr(CSR_ROW_BYTES, CSR_DATA_W'(120));
      write_csr(CSR_ROW_SAMPLES, CSR_DATA_W'(100));
      @(negedge clock);
      repeat (40) raw_bytes_to_send.push_back(random_raw_byte());
      hold_requested = hold_requested + 1;
      wait_drained();

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
sv/rsru_pkg.sv
sv/raw_sensor_row_unpacker_unit.sv
verif/raw_sensor_row_unpacker_unit_tb.sv
